FILE: hdl/vcbdf_pkg.sv
// Shared types and constants for the voxel city-block distance field.
// Used by the channel interfaces and by the top level; depends on nothing.

package vcbdf_pkg;

   // Default grid extent along each axis.
   localparam int DEF_MAX_X = 32;
   localparam int DEF_MAX_Y = 32;
   localparam int DEF_MAX_Z = 32;

   // Field widths.
   localparam int OP_W   = 2;
   localparam int POS_W  = 5;
   localparam int SIZE_W = 6;
   localparam int DIST_W = 8;
   localparam int PRES_W = 17;
   localparam int IDX_W  = 2;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OP_W-1:0] OP_START = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;

   // Register indexes.
   localparam logic [IDX_W-1:0] CSR_SIZE_X = 2'd0;
   localparam logic [IDX_W-1:0] CSR_SIZE_Y = 2'd1;
   localparam logic [IDX_W-1:0] CSR_SIZE_Z = 2'd2;

   localparam logic [SIZE_W-1:0] SIZE_RESET   = 6'd32;
   localparam logic [DIST_W-1:0] UNREACHED    = 8'd255;
   localparam int unsigned       PRESSURE_ONE = 65536;
   localparam int                RECIP_DEPTH  = 256;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN_X,
      ST_SCAN_Y,
      ST_SCAN_Z,
      ST_DRAIN
   } scan_state_type;

endpackage

FILE: hdl/vcbdf_ifs.sv
// Channel interfaces for the voxel city-block distance field: request,
// response and register write. Depends on vcbdf_pkg for field widths.

interface vcbdf_req_if;
   import vcbdf_pkg::*;
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [POS_W-1:0]  pos_x;
   logic [POS_W-1:0]  pos_y;
   logic [POS_W-1:0]  pos_z;
   logic              occupied;
   modport source (output valid, operation, pos_x, pos_y, pos_z, occupied, input ready);
   modport sink   (input valid, operation, pos_x, pos_y, pos_z, occupied, output ready);
endinterface

interface vcbdf_rsp_if;
   import vcbdf_pkg::*;
   logic              valid;
   logic              ready;
   logic [DIST_W-1:0] distance;
   logic [PRES_W-1:0] pressure;
   modport source (output valid, distance, pressure, input ready);
   modport sink   (input valid, distance, pressure, output ready);
endinterface

interface vcbdf_csr_if;
   import vcbdf_pkg::*;
   logic              valid;
   logic              ready;
   logic [IDX_W-1:0]  index;
   logic [SIZE_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/voxel_city_block_distance_field.sv
// Top level of the voxel city-block distance field: occupancy and distance
// stores, the six-pass min-plus scan sequencer and the read result path.
// Depends on vcbdf_pkg and the channel interfaces in vcbdf_ifs.sv.
//
//   channel    direction   carries
//   req_chan   in          operation, pos_x, pos_y, pos_z, occupied
//   rsp_chan   out         distance, pressure (one item per read)
//   csr_chan   in          index, data (size_x, size_y, size_z)
//
// Writes and reads are accepted one per cycle while the sequencer is idle and
// no read result is held up; a read result goes through the read data register
// and then a response register. A start runs six passes; each visits every voxel once
// through the single read-modify-write port of the distance store.
// Reset clears control state only; no clearing pass runs over the stores.
// A stalled response holds; a second read then waits in the read data register.

module voxel_city_block_distance_field #(
   parameter int MAX_X = vcbdf_pkg::DEF_MAX_X,
   parameter int MAX_Y = vcbdf_pkg::DEF_MAX_Y,
   parameter int MAX_Z = vcbdf_pkg::DEF_MAX_Z
) (
   input logic          clock,
   input logic          reset,
   vcbdf_req_if.sink    req_chan,
   vcbdf_rsp_if.source  rsp_chan,
   vcbdf_csr_if.sink    csr_chan
);
   import vcbdf_pkg::*;

   localparam int XW    = $clog2(MAX_X);
   localparam int YW    = $clog2(MAX_Y);
   localparam int ZW    = $clog2(MAX_Z);
   localparam int AW    = XW + YW + ZW;
   localparam int DEPTH = 2 ** AW;

   // Stores.
   logic              occ_mem  [DEPTH];
   logic [DIST_W-1:0] dist_mem [DEPTH];

   // Configuration.
   logic [SIZE_W-1:0] size_x_ff, size_y_ff, size_z_ff;
   logic [SIZE_W-1:0] eff_x, eff_y, eff_z;
   logic [SIZE_W-1:0] lim_x_ff, lim_y_ff, lim_z_ff;

   // Sequencer.
   scan_state_type    state_ff, state_in;
   logic [SIZE_W-1:0] cx_ff, cy_ff, cz_ff, cx_in, cy_in, cz_in;
   logic              bwd_ff, bwd_in;
   logic [SIZE_W-1:0] inner, l_in, o1, l1, o2, l2;
   logic [SIZE_W-1:0] inner_n, o1_n, o2_n;
   logic              line_end, first, axis_done;
   logic              scan_issue, from_occ, req_ready_c;

   // Scan datapath.
   logic [AW-1:0]     scan_addr, req_addr, rd_addr;
   logic              dv_ff, dv_first_ff, dv_occ_ff;
   logic [AW-1:0]     dv_addr_ff;
   logic              occ_rd_ff;
   logic [DIST_W-1:0] dist_rd_ff;
   logic              byp_hit_ff;
   logic [DIST_W-1:0] byp_ff;
   logic [DIST_W-1:0] run_ff;
   logic [DIST_W-1:0] d_cur, run_base, cand, new_d;
   logic              dist_rd_en;

   // Request and response.
   logic              req_fire, in_region, start_go, slot_free;
   logic              pend_ff, pend_in, pend_inside_ff;
   logic              rsp_valid_ff;
   logic [DIST_W-1:0] rsp_dist_ff, rsp_dist_c;
   logic [PRES_W-1:0] rsp_pres_ff;
   logic [PRES_W-1:0] recip_tbl [RECIP_DEPTH];

   // Pressure table: 65536 at zero, nothing when unreached, else the truncated reciprocal.
   for (genvar gi = 0; gi < RECIP_DEPTH; gi++) begin : g_recip
      localparam int unsigned QV = (gi == 0) ? PRESSURE_ONE :
                                   (gi == RECIP_DEPTH - 1) ? 0 :
                                   PRESSURE_ONE / ((gi == 0) ? 1 : gi);
      assign recip_tbl[gi] = PRES_W'(QV);
   end

   // ---------------------------------------------------------------- config
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= SIZE_RESET;
         size_y_ff <= SIZE_RESET;
         size_z_ff <= SIZE_RESET;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_SIZE_X: size_x_ff <= csr_chan.data;
            CSR_SIZE_Y: size_y_ff <= csr_chan.data;
            CSR_SIZE_Z: size_z_ff <= csr_chan.data;
            default: ;
         endcase
      end
   end

   always_comb begin
      eff_x = (int'(size_x_ff) > MAX_X) ? SIZE_W'(MAX_X) : size_x_ff;
      eff_y = (int'(size_y_ff) > MAX_Y) ? SIZE_W'(MAX_Y) : size_y_ff;
      eff_z = (int'(size_z_ff) > MAX_Z) ? SIZE_W'(MAX_Z) : size_z_ff;
   end

   // ------------------------------------------------------------- requests
   assign req_fire  = req_chan.valid && req_chan.ready;
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign in_region = ({1'b0, req_chan.pos_x} < eff_x) &&
                      ({1'b0, req_chan.pos_y} < eff_y) &&
                      ({1'b0, req_chan.pos_z} < eff_z);
   assign start_go  = req_fire && (req_chan.operation == OP_START) &&
                      (eff_x != '0) && (eff_y != '0) && (eff_z != '0);
   assign req_addr  = {ZW'(req_chan.pos_z), YW'(req_chan.pos_y), XW'(req_chan.pos_x)};
   assign scan_addr = {ZW'(cz_ff), YW'(cy_ff), XW'(cx_ff)};
   assign req_chan.ready = req_ready_c;

   always_ff @(posedge clock) begin
      if (start_go) begin
         lim_x_ff <= eff_x - 1'b1;
         lim_y_ff <= eff_y - 1'b1;
         lim_z_ff <= eff_z - 1'b1;
      end
   end

   // ------------------------------------------------------------ sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (start_go) state_in = ST_SCAN_X;
         ST_SCAN_X: if (axis_done) state_in = ST_SCAN_Y;
         ST_SCAN_Y: if (axis_done) state_in = ST_SCAN_Z;
         ST_SCAN_Z: if (axis_done) state_in = ST_DRAIN;
         ST_DRAIN:  state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      scan_issue  = state_ff inside {ST_SCAN_X, ST_SCAN_Y, ST_SCAN_Z};
      from_occ    = (state_ff == ST_SCAN_X) && !bwd_ff;
      req_ready_c = (state_ff == ST_IDLE) && (!pend_ff || slot_free);
   end

   // Each axis walks its lines forward then backward; the other two axes
   // count lines. The counters are mapped onto x, y and z by the axis.
   always_comb begin
      case (state_ff)
         ST_SCAN_Y: begin
            inner = cy_ff; l_in = lim_y_ff;
            o1 = cx_ff; l1 = lim_x_ff; o2 = cz_ff; l2 = lim_z_ff;
         end
         ST_SCAN_Z: begin
            inner = cz_ff; l_in = lim_z_ff;
            o1 = cx_ff; l1 = lim_x_ff; o2 = cy_ff; l2 = lim_y_ff;
         end
         default: begin
            inner = cx_ff; l_in = lim_x_ff;
            o1 = cy_ff; l1 = lim_y_ff; o2 = cz_ff; l2 = lim_z_ff;
         end
      endcase

      line_end  = bwd_ff ? (inner == '0) : (inner == l_in);
      first     = bwd_ff ? (inner == l_in) : (inner == '0);
      axis_done = line_end && bwd_ff && (o1 == l1) && (o2 == l2);

      inner_n = inner;
      o1_n    = o1;
      o2_n    = o2;
      bwd_in  = bwd_ff;
      if (!line_end) begin
         inner_n = bwd_ff ? inner - 1'b1 : inner + 1'b1;
      end else if (!bwd_ff) begin
         // The backward sweep starts on the cell where the forward one ended.
         bwd_in = 1'b1;
      end else begin
         bwd_in  = 1'b0;
         inner_n = '0;
         if (o1 == l1) begin
            o1_n = '0;
            o2_n = (o2 == l2) ? '0 : o2 + 1'b1;
         end else begin
            o1_n = o1 + 1'b1;
         end
      end

      case (state_ff)
         ST_SCAN_Y: begin cx_in = o1_n; cy_in = inner_n; cz_in = o2_n; end
         ST_SCAN_Z: begin cx_in = o1_n; cy_in = o2_n; cz_in = inner_n; end
         default:   begin cx_in = inner_n; cy_in = o1_n; cz_in = o2_n; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cx_ff    <= '0;
         cy_ff    <= '0;
         cz_ff    <= '0;
         bwd_ff   <= 1'b0;
         dv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         dv_ff    <= scan_issue;
         if (scan_issue) begin
            cx_ff  <= cx_in;
            cy_ff  <= cy_in;
            cz_ff  <= cz_in;
            bwd_ff <= bwd_in;
         end
      end
   end

   // --------------------------------------------------------- scan datapath
   assign rd_addr    = scan_issue ? scan_addr : req_addr;
   assign dist_rd_en = (scan_issue && !from_occ) ||
                       (req_fire && (req_chan.operation == OP_READ) && in_region);

   always_comb begin
      if (dv_occ_ff) begin
         d_cur = occ_rd_ff ? '0 : UNREACHED;
      end else begin
         d_cur = byp_hit_ff ? byp_ff : dist_rd_ff;
      end
      run_base = dv_first_ff ? UNREACHED : run_ff;
      cand     = (run_base == UNREACHED) ? UNREACHED : run_base + 1'b1;
      new_d    = (cand < d_cur) ? cand : d_cur;
   end

   always_ff @(posedge clock) begin
      dv_addr_ff  <= scan_addr;
      dv_first_ff <= first;
      dv_occ_ff   <= from_occ;
      // A read that lands on the cell being written this cycle takes the new value.
      byp_hit_ff  <= dv_ff && (dv_addr_ff == scan_addr);
      byp_ff      <= new_d;
      if (dv_ff) begin
         run_ff <= new_d;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && (req_chan.operation == OP_WRITE) && in_region) begin
         occ_mem[req_addr] <= req_chan.occupied;
      end
      if (scan_issue && from_occ) begin
         occ_rd_ff <= occ_mem[scan_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (dv_ff) begin
         dist_mem[dv_addr_ff] <= new_d;
      end
      if (dist_rd_en) begin
         dist_rd_ff <= dist_mem[rd_addr];
      end
   end

   // ------------------------------------------------------------- response
   always_comb begin
      pend_in = pend_ff;
      if (req_fire && (req_chan.operation == OP_READ)) begin
         pend_in = 1'b1;
      end else if (pend_ff && slot_free) begin
         pend_in = 1'b0;
      end
      rsp_dist_c = pend_inside_ff ? dist_rd_ff : UNREACHED;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
         if (pend_ff && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && (req_chan.operation == OP_READ)) begin
         pend_inside_ff <= in_region;
      end
      if (pend_ff && slot_free) begin
         rsp_dist_ff <= rsp_dist_c;
         rsp_pres_ff <= recip_tbl[rsp_dist_c];
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.distance = rsp_dist_ff;
   assign rsp_chan.pressure = rsp_pres_ff;

endmodule
